/* rtl/bss_pkg.sv */
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the bitplane strip shifter.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned Lanes  = 5;
  localparam int unsigned ShiftW = 3;
  localparam int unsigned DataW  = Lanes * ByteW;

  // Control that every lane sees for one strip
  typedef struct packed {
    logic              accept;
    logic              row_end;
    logic [ShiftW-1:0] shift;
  } bss_lane_ctrl_t;

  // One output word: packed strip plus row-done flag
  typedef struct packed {
    logic             last;
    logic [DataW-1:0] data;
  } bss_word_t;

endpackage

/* rtl/bss_lane.sv */
// ----------------------------------------------------------------------------
// bss_lane
// Shifts one byte right and holds the bits that fall off as the carry
// for the next strip of the row.
// ----------------------------------------------------------------------------
module bss_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bss_pkg::bss_lane_ctrl_t          ctrl_i,
  input  logic [bss_pkg::ByteW-1:0]        byte_i,
  output logic [bss_pkg::ByteW-1:0]        merged_o,
  output logic [bss_pkg::ByteW-1:0]        spill_o
);
  import bss_pkg::*;

  logic [2*ByteW-1:0] wide;
  logic [ByteW-1:0]   carry_q;
  logic [ByteW-1:0]   carry_d;

  // high byte goes out now, low byte carries on
  assign wide     = {byte_i, {ByteW{1'b0}}} >> ctrl_i.shift;
  assign merged_o = carry_q | wide[2*ByteW-1:ByteW];
  assign spill_o  = wide[ByteW-1:0];

  always_comb begin
    carry_d = carry_q;
    if (ctrl_i.accept) begin
      // drop the carry once it is flushed at the row end
      carry_d = ctrl_i.row_end ? '0 : spill_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

endmodule

/* rtl/bss_outq.sv */
// ----------------------------------------------------------------------------
// bss_outq
// Merges the lane results into output words and queues them; a row end
// pushes the merged strip and the flushed carry strip in the same cycle.
// ----------------------------------------------------------------------------
module bss_outq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         row_end_i,
  input  logic [bss_pkg::DataW-1:0]    merged_i,
  input  logic [bss_pkg::DataW-1:0]    spill_i,
  output logic                         room_o,
  output bss_pkg::bss_word_t           word_o,
  output logic                         valid_o,
  input  logic                         ready_i
);
  import bss_pkg::*;

  localparam int unsigned Depth = 3;

  bss_word_t  mem_q [Depth];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q,  count_d;
  logic [1:0] wr_next;
  logic       push_two;
  logic       pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    ptr_inc = (p == 2'(Depth - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign push_two = push_i & row_end_i;
  assign pop      = valid_o & ready_i;
  assign wr_next  = ptr_inc(wr_ptr_q);

  assign valid_o = (count_q != 2'd0);
  assign room_o  = (count_q <= 2'd1);
  assign word_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = push_two ? ptr_inc(wr_next) : wr_next;
    end
    if (pop) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
    end
    count_d = count_q + 2'(push_i) + 2'(push_two) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= '{last: 1'b0, data: merged_i};
    end
    if (push_two) begin
      mem_q[wr_next] <= '{last: 1'b1, data: spill_i};
    end
  end

endmodule

/* rtl/bitplane_strip_shifter_top.sv */
// ----------------------------------------------------------------------------
// bitplane_strip_shifter_top
// Shifts 8-pixel bitplane strips right with carry into the next strip and
// emits a carry strip at each row end.
// ----------------------------------------------------------------------------
// An accepted strip is registered in the output queue before it leaves as its output word.
// Throughput: one strip per cycle while the output queue has room; a row-end strip makes two
//   words, so the input holds off after it until the sink takes a word.
// Reset: clears the shift register, all lane carries and the output queue.
module bitplane_strip_shifter_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bss_pkg::ShiftW-1:0] cfg_wdata_i,     // pixel_shift
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bss_pkg::DataW-1:0]  s_axis_tdata,    // in_plane0..3, in_mask
  input  logic                       s_axis_tlast,    // row_end
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [bss_pkg::DataW-1:0]  m_axis_tdata,    // out_plane0..3, out_mask
  output logic                       m_axis_tlast     // row_done
);
  import bss_pkg::*;

  logic [ShiftW-1:0] shift_q;
  logic [ShiftW-1:0] shift_d;
  bss_lane_ctrl_t    lane_ctrl;
  logic [DataW-1:0]  merged;
  logic [DataW-1:0]  spill;
  logic              accept;
  bss_word_t         word;

  assign shift_d = cfg_we_i ? cfg_wdata_i : shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else begin
      shift_q <= shift_d;
    end
  end

  assign accept    = s_axis_tvalid & s_axis_tready;
  assign lane_ctrl = '{accept: accept, row_end: s_axis_tlast, shift: shift_q};

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    bss_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .byte_i   (s_axis_tdata[g*ByteW +: ByteW]),
      .merged_o (merged[g*ByteW +: ByteW]),
      .spill_o  (spill[g*ByteW +: ByteW])
    );
  end

  bss_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept),
    .row_end_i (s_axis_tlast),
    .merged_i  (merged),
    .spill_i   (spill),
    .room_o    (s_axis_tready),
    .word_o    (word),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready)
  );

  assign m_axis_tdata = word.data;
  assign m_axis_tlast = word.last;

endmodule
